>>> rtl/ubq_pkg.sv
// ----------------------------------------------------------------------------
// ubq_pkg: shared types and codes for the buffered uart byte queues
// opcodes, the pipeline stage record and the packed result layout
// ----------------------------------------------------------------------------
package ubq_pkg;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_GET   = 2'd1;
  localparam logic [1:0] OP_RX    = 2'd2;
  localparam logic [1:0] OP_TXRDY = 2'd3;

  localparam int RESULT_W = 20;
  localparam int TDATA_W  = 24;

  typedef struct packed {
    logic       rd_valid;
    logic       ln_send;
    logic       ln_from_mem;
    logic       drop;
    logic       busy;
    logic [7:0] ln_byte;
  } stage_t;

  // packed from the lowest bit up: read_byte, read_valid, line_byte,
  // line_send, dropped, busy_out
  typedef struct packed {
    logic       busy_out;
    logic       dropped;
    logic       line_send;
    logic [7:0] line_byte;
    logic       read_valid;
    logic [7:0] read_byte;
  } result_t;

endpackage

>>> rtl/ubq_ring_mem.sv
// ----------------------------------------------------------------------------
// ubq_ring_mem: byte store behind one ring
// one write port and one read port, read data registered
// ----------------------------------------------------------------------------
module ubq_ring_mem #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/uart_buffered_byte_queues.sv
// ----------------------------------------------------------------------------
// uart_buffered_byte_queues: receive and transmit byte rings of a uart
// pipeline: an input stage and then the result register, since
// the ring memory read data is registered
// throughput: one transaction per cycle while m_axis_tready stays high
// reset: pointers, transmitter busy flag and stage valids clear at once
// ring stores are not cleared; an entry is only read after it was written
// ----------------------------------------------------------------------------
module uart_buffered_byte_queues
  import ubq_pkg::*;
#(
  parameter int RING_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // data_byte
  input  logic [1:0]         s_axis_tuser,   // opcode
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // read_byte, read_valid, line_byte, line_send, dropped, busy_out, zero pad
  output logic [TDATA_W-1:0] m_axis_tdata
);

  localparam int PTR_W = $clog2(RING_DEPTH);

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    ring_next = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  logic [PTR_W-1:0] rx_head, rx_tail, tx_head, tx_tail;
  logic [PTR_W-1:0] rx_head_next, rx_tail_next, tx_head_next, tx_tail_next;
  logic             busy, busy_next;

  logic    accept;
  logic    s1_valid, s1_adv;
  stage_t  s1, s1_next;
  logic    m_valid;
  result_t out_q;

  logic rx_wr, rx_rd, tx_wr, tx_rd;
  logic [7:0] rx_rd_data, tx_rd_data;

  assign s1_adv        = s1_valid & (~m_valid | m_axis_tready);
  assign s_axis_tready = ~s1_valid | s1_adv;
  assign accept        = s_axis_tvalid & s_axis_tready;

  always_comb begin
    rx_head_next = rx_head;
    rx_tail_next = rx_tail;
    tx_head_next = tx_head;
    tx_tail_next = tx_tail;
    busy_next    = busy;
    rx_wr        = 1'b0;
    rx_rd        = 1'b0;
    tx_wr        = 1'b0;
    tx_rd        = 1'b0;
    s1_next      = '0;
    unique case (s_axis_tuser)
      OP_PUT: begin
        if (!busy) begin
          busy_next       = 1'b1;
          s1_next.ln_send = 1'b1;
          s1_next.ln_byte = s_axis_tdata;
        end else if (ring_next(tx_head) != tx_tail) begin
          tx_wr        = 1'b1;
          tx_head_next = ring_next(tx_head);
        end else begin
          s1_next.drop = 1'b1;
        end
      end
      OP_GET: begin
        if (rx_head != rx_tail) begin
          rx_rd            = 1'b1;
          s1_next.rd_valid = 1'b1;
          rx_tail_next     = ring_next(rx_tail);
        end
      end
      OP_RX: begin
        if (ring_next(rx_head) != rx_tail) begin
          rx_wr        = 1'b1;
          rx_head_next = ring_next(rx_head);
        end else begin
          s1_next.drop = 1'b1;
        end
      end
      OP_TXRDY: begin
        if (tx_head == tx_tail) begin
          busy_next = 1'b0;
        end else begin
          tx_rd               = 1'b1;
          s1_next.ln_send     = 1'b1;
          s1_next.ln_from_mem = 1'b1;
          tx_tail_next        = ring_next(tx_tail);
        end
      end
      default: begin
      end
    endcase
    s1_next.busy = busy_next;
  end

  ubq_ring_mem #(.DEPTH(RING_DEPTH)) rx_mem (
    .clk     (clk),
    .wr_en   (accept & rx_wr),
    .wr_addr (rx_head),
    .wr_data (s_axis_tdata),
    .rd_en   (accept & rx_rd),
    .rd_addr (rx_tail),
    .rd_data (rx_rd_data)
  );

  ubq_ring_mem #(.DEPTH(RING_DEPTH)) tx_mem (
    .clk     (clk),
    .wr_en   (accept & tx_wr),
    .wr_addr (tx_head),
    .wr_data (s_axis_tdata),
    .rd_en   (accept & tx_rd),
    .rd_addr (tx_tail),
    .rd_data (tx_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_head  <= '0;
      rx_tail  <= '0;
      tx_head  <= '0;
      tx_tail  <= '0;
      busy     <= 1'b0;
      s1_valid <= 1'b0;
      m_valid  <= 1'b0;
    end else begin
      if (accept) begin
        rx_head  <= rx_head_next;
        rx_tail  <= rx_tail_next;
        tx_head  <= tx_head_next;
        tx_tail  <= tx_tail_next;
        busy     <= busy_next;
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        m_valid <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
    if (s1_adv) begin
      out_q.read_byte  <= s1.rd_valid ? rx_rd_data : 8'd0;
      out_q.read_valid <= s1.rd_valid;
      out_q.line_byte  <= s1.ln_send ? (s1.ln_from_mem ? tx_rd_data : s1.ln_byte) : 8'd0;
      out_q.line_send  <= s1.ln_send;
      out_q.dropped    <= s1.drop;
      out_q.busy_out   <= s1.busy;
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {(TDATA_W - RESULT_W)'(0), out_q};

`ifndef SYNTHESIS
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    int'(rx_head) < RING_DEPTH && int'(rx_tail) < RING_DEPTH &&
    int'(tx_head) < RING_DEPTH && int'(tx_tail) < RING_DEPTH)
    else $error("ring pointer beyond depth");

  a_idle_tx_empty: assert property (@(posedge clk) disable iff (rst)
    !busy |-> tx_head == tx_tail)
    else $error("transmitter idle with bytes queued");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1))
    else $error("stalled stage lost its transaction");

  a_send_busy: assert property (@(posedge clk) disable iff (rst)
    m_valid && out_q.line_send |-> out_q.busy_out)
    else $error("line send reported with transmitter idle");

  a_flags_apart: assert property (@(posedge clk) disable iff (rst)
    m_valid && out_q.read_valid |-> !out_q.line_send && !out_q.dropped)
    else $error("get result carries send or drop flag");
`endif

endmodule

>>> test/tb_uart_buffered_byte_queues.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uart_buffered_byte_queues: self-checking bench for the uart byte queues
// directed transactions cover the empty rings, the transmit bypass and drain,
// and the receive path. Random bursts then favour one opcode each, so that the
// rings fill to the drop point and drain again. A local predictor keeps its
// own copy of both rings and the busy flag. Each output transaction is checked
// field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_uart_buffered_byte_queues;
  import ubq_pkg::*;

  localparam int RING_DEPTH = 64;
  localparam int PTR_W      = $clog2(RING_DEPTH);

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata  = 8'h00;   // data_byte
  logic [1:0]         s_axis_tuser  = OP_GET;  // opcode
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  // read_byte, read_valid, line_byte, line_send, dropped, busy_out, zero pad
  logic [TDATA_W-1:0] m_axis_tdata;

  int      send_idle_pct  = 0;
  int      recv_stall_pct = 0;
  int      err_count      = 0;
  result_t pending_results[$];

  // predictor state
  logic [7:0]       rx_ring [RING_DEPTH];
  logic [7:0]       tx_ring [RING_DEPTH];
  logic [PTR_W-1:0] rx_wr_ptr, rx_rd_ptr, tx_wr_ptr, tx_rd_ptr;
  logic             tx_busy;

  uart_buffered_byte_queues #(.RING_DEPTH(RING_DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic result_t predict_queue_result(input logic [1:0] op,
                                                   input logic [7:0] data);
    result_t r;
    r = '0;
    case (op)
      OP_PUT: begin
        if (!tx_busy) begin
          tx_busy     = 1'b1;
          r.line_byte = data;
          r.line_send = 1'b1;
        end else if (PTR_W'(tx_wr_ptr + 1) != tx_rd_ptr) begin
          tx_ring[tx_wr_ptr] = data;
          tx_wr_ptr          = PTR_W'(tx_wr_ptr + 1);
        end else begin
          r.dropped = 1'b1;
        end
      end
      OP_GET: begin
        if (rx_wr_ptr != rx_rd_ptr) begin
          r.read_byte  = rx_ring[rx_rd_ptr];
          r.read_valid = 1'b1;
          rx_rd_ptr    = PTR_W'(rx_rd_ptr + 1);
        end
      end
      OP_RX: begin
        if (PTR_W'(rx_wr_ptr + 1) != rx_rd_ptr) begin
          rx_ring[rx_wr_ptr] = data;
          rx_wr_ptr          = PTR_W'(rx_wr_ptr + 1);
        end else begin
          r.dropped = 1'b1;
        end
      end
      default: begin
        if (tx_wr_ptr == tx_rd_ptr) begin
          tx_busy = 1'b0;
        end else begin
          r.line_byte = tx_ring[tx_rd_ptr];
          r.line_send = 1'b1;
          tx_rd_ptr   = PTR_W'(tx_rd_ptr + 1);
        end
      end
    endcase
    r.busy_out = tx_busy;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    err_count++;
  endtask

  // tvalid stays high after acceptance; it is only lowered for an idle gap
  task automatic send_transaction(input logic [1:0] op, input logic [7:0] data);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= data;
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(predict_queue_result(op, data));
  endtask

  always @(posedge clk) begin : result_check
    result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[RESULT_W-1:0]);
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction", int'(got), 0);
      end else begin
        want = pending_results.pop_front();
        if (got.read_byte !== want.read_byte)
          report_mismatch("read_byte", got.read_byte, want.read_byte);
        if (got.read_valid !== want.read_valid)
          report_mismatch("read_valid", got.read_valid, want.read_valid);
        if (got.line_byte !== want.line_byte)
          report_mismatch("line_byte", got.line_byte, want.line_byte);
        if (got.line_send !== want.line_send)
          report_mismatch("line_send", got.line_send, want.line_send);
        if (got.dropped !== want.dropped)
          report_mismatch("dropped", got.dropped, want.dropped);
        if (got.busy_out !== want.busy_out)
          report_mismatch("busy_out", got.busy_out, want.busy_out);
        if (m_axis_tdata[TDATA_W-1:RESULT_W] !== '0)
          report_mismatch("pad bits", int'(m_axis_tdata[TDATA_W-1:RESULT_W]), 0);
      end
    end
  end

  task automatic test_empty_and_idle;
    send_transaction(OP_GET, 8'hFF);
    send_transaction(OP_TXRDY, 8'hFF);
    send_transaction(OP_TXRDY, 8'h00);
  endtask

  task automatic test_transmit_path;
    send_transaction(OP_PUT, 8'h00);
    send_transaction(OP_PUT, 8'hFF);
    send_transaction(OP_PUT, 8'hA5);
    send_transaction(OP_TXRDY, 8'h00);
    send_transaction(OP_TXRDY, 8'h00);
    send_transaction(OP_TXRDY, 8'h00);
    send_transaction(OP_PUT, 8'h5A);
    send_transaction(OP_TXRDY, 8'hFF);
  endtask

  task automatic test_receive_path;
    send_transaction(OP_RX, 8'h00);
    send_transaction(OP_RX, 8'hFF);
    send_transaction(OP_RX, 8'h5A);
    send_transaction(OP_GET, 8'h00);
    send_transaction(OP_GET, 8'h00);
    send_transaction(OP_GET, 8'h00);
    send_transaction(OP_GET, 8'h00);
    send_transaction(OP_RX, 8'hA5);
    send_transaction(OP_GET, 8'hFF);
  endtask

  // bursts that favour one opcode fill a ring to the drop point or drain it
  task automatic test_random_traffic(input int n_items);
    int         left;
    int         burst;
    int         favour_pct;
    logic [1:0] favoured;
    left = n_items;
    while (left > 0) begin
      favoured   = 2'($urandom_range(0, 3));
      favour_pct = ($urandom_range(0, 3) != 0) ? 85 : 25;
      burst      = $urandom_range(40, 110);
      if (burst > left) burst = left;
      repeat (burst) begin
        if ($urandom_range(0, 99) < favour_pct)
          send_transaction(favoured, 8'($urandom));
        else
          send_transaction(2'($urandom), 8'($urandom));
      end
      left -= burst;
    end
  endtask

  initial begin
    rx_wr_ptr = '0;
    rx_rd_ptr = '0;
    tx_wr_ptr = '0;
    tx_rd_ptr = '0;
    tx_busy   = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct  = 10;
    recv_stall_pct = 60;
    test_empty_and_idle;
    test_transmit_path;
    test_receive_path;
    test_random_traffic(150);

    send_idle_pct  = 60;
    recv_stall_pct = 10;
    test_random_traffic(150);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(150);

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_uart_buffered_byte_queues: clean");
    end else begin
      $display("tb_uart_buffered_byte_queues: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("tb_uart_buffered_byte_queues: errors");
    $finish;
  end

endmodule
